FILE: src/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned DefEntries = 32;
  localparam logic [7:0]  NotProvided = 8'd255;
  localparam logic [15:0] DefLifetime = 16'd600;

  typedef enum logic [2:0] {
    MODE_ADV     = 3'd0,
    MODE_REFRESH = 3'd1,
    MODE_TICK    = 3'd2,
    MODE_SWEEP   = 3'd3,
    MODE_LOOKUP  = 3'd4,
    MODE_BEST    = 3'd5,
    MODE_DUMP    = 3'd6,
    MODE_NONE    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_FULL     = 3'd2,
    ST_METRIC   = 3'd3,
    ST_LOCAL    = 3'd4
  } status_e;

  localparam logic CfgLocal    = 1'b0;
  localparam logic CfgLifetime = 1'b1;

  // One route entry as stored in memory.
  typedef struct packed {
    logic [15:0] dest;
    logic [15:0] via;
    logic [7:0]  hops;
    logic [7:0]  role;
    logic [7:0]  load;
    logic [7:0]  snr;
    logic [15:0] age;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

FILE: src/dvrt_ram.sv
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dvrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: src/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Ordered hop-count route table kept in one entry memory, scanned per command.
// ----------------------------------------------------------------------------
// Every entry is read through the single memory port. Apart from advertise,
// a command keeps busy high for one cycle on an empty table, as does the
// unused mode. Otherwise the scan reads the entries in order; refresh, lookup
// and the first advertise pass stop at the first hit. Advertise passes the
// table a second time for the sender SNR when from_sender_i is set. It steps
// through decide, write-back, SNR write and result as each applies. Results
// appear on a one-cycle strobe (result_valid_o) that the receiver cannot
// stall. The strobe comes as busy falls. Dump emits one strobe per entry read
// during its scan, and the strobe with last_o comes as busy falls. No
// clearing pass after reset.
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int unsigned TableEntries = DefEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [2:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [15:0] via_i,
  input  logic [7:0]  metric_i,
  input  logic [7:0]  role_i,
  input  logic [7:0]  load_i,
  input  logic signed [7:0] snr_i,
  input  logic        from_sender_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] entry_address_o,
  output logic [15:0] next_hop_o,
  output logic [7:0]  hops_o,
  output logic [7:0]  entry_role_o,
  output logic [7:0]  entry_load_o,
  output logic signed [7:0] entry_snr_o,
  output logic [5:0]  entry_count_o,
  output logic        last_o
);
  localparam int unsigned AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CW = $clog2(TableEntries + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_DECIDE, S_WR, S_SRD, S_SCHK, S_SWR, S_DONE
  } state_e;

  state_e state_q;
  logic [15:0] local_q, life_q;
  logic [2:0]  mode_q;
  logic [15:0] addr_q, via_q, dst_q;
  logic [7:0]  metric_q, role_q, load_q, snr_q, maxh_q;
  logic        sender_q, found_q, best_q;
  logic [AW-1:0] idx_q, wr_q, hit_q;
  logic [CW-1:0] cnt_q;
  logic [2:0]  st_q;
  entry_t      hit_e_q;
  entry_t      res_q;

  logic          we;
  logic [AW-1:0] ram_a;
  entry_t        wdata, rdata;
  logic [EntryW-1:0] rraw;

  assign rdata = entry_t'(rraw);

  dvrt_ram #(.Width(EntryW), .Depth(1 << AW)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ram_a), .wdata_i(wdata), .rdata_o(rraw)
  );

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Scan helpers.
  logic [CW-1:0] idx_ext, idx_nx;
  logic          at_end;
  logic          scan_hit;
  assign idx_ext = CW'(idx_q);
  assign idx_nx  = idx_ext + CW'(1);
  assign at_end  = (idx_nx >= cnt_q);
  assign scan_hit = ((mode_e'(mode_q) == MODE_ADV) && (rdata.dest == dst_q)) ||
                    ((mode_e'(mode_q) == MODE_REFRESH || mode_e'(mode_q) == MODE_LOOKUP) &&
                     (rdata.dest == addr_q));

  logic [8:0] m_full;
  logic [7:0] m_eff;
  assign m_full = from_sender_i ? 9'd1 : {1'b0, metric_i} + 9'd1;
  assign m_eff  = m_full[8] ? 8'd255 : m_full[7:0];

  // Modified entry for advertise hit.
  entry_t adv_e;
  always_comb begin
    adv_e = hit_e_q;
    if (metric_q < hit_e_q.hops) begin
      adv_e.hops = metric_q;
      adv_e.via  = via_q;
      adv_e.age  = '0;
    end else if (metric_q == hit_e_q.hops) begin
      adv_e.age = '0;
    end
    if (load_q != NotProvided) adv_e.load = load_q;
    if (adv_e.via == via_q) adv_e.role = role_q;
  end

  always_comb begin
    we    = 1'b0;
    ram_a = idx_q;
    wdata = rdata;
    unique case (state_q)
      S_WR: begin
        we = 1'b1;
        ram_a = wr_q;
        wdata = hit_e_q;
      end
      S_SWR: begin
        we = 1'b1;
        ram_a = hit_q;
        wdata = hit_e_q;
        wdata.snr = snr_q;
      end
      S_CHK: begin
        ram_a = wr_q;
        wdata = rdata;
        unique case (mode_e'(mode_q))
          MODE_TICK: begin
            we = 1'b1;
            ram_a = idx_q;
            if (rdata.age != 16'hFFFF) wdata.age = rdata.age + 16'd1;
          end
          MODE_SWEEP: begin
            we = (rdata.age <= life_q);
          end
          MODE_REFRESH: begin
            we = (rdata.dest == addr_q);
            ram_a = idx_q;
            wdata.age = '0;
          end
          default: we = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      local_q <= '0;
      life_q  <= DefLifetime;
      cnt_q   <= '0;
      result_valid_o <= 1'b0;
      last_o  <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      last_o <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgLocal) local_q <= cfg_data_i;
        else life_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q   <= mode_i;
            addr_q   <= address_i;
            via_q    <= via_i;
            dst_q    <= from_sender_i ? via_i : address_i;
            metric_q <= m_eff;
            role_q   <= role_i;
            load_q   <= load_i;
            snr_q    <= snr_i;
            sender_q <= from_sender_i;
            found_q  <= 1'b0;
            best_q   <= 1'b0;
            maxh_q   <= '0;
            idx_q    <= '0;
            wr_q     <= '0;
            st_q     <= ST_OK;
            if (mode_e'(mode_i) == MODE_ADV &&
                (from_sender_i ? via_i : address_i) == local_q) begin
              st_q  <= ST_LOCAL;
              state_q <= (from_sender_i && cnt_q != '0) ? S_SRD : S_DONE;
            end else if (cnt_q == '0 || mode_e'(mode_i) == MODE_NONE) begin
              state_q <= (mode_e'(mode_i) == MODE_ADV) ? S_DECIDE : S_DONE;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          unique case (mode_e'(mode_q))
            MODE_ADV: begin
              if (rdata.hops > maxh_q) maxh_q <= rdata.hops;
              if (rdata.dest == dst_q) begin
                found_q <= 1'b1; hit_q <= idx_q; hit_e_q <= rdata;
              end
            end
            MODE_REFRESH, MODE_LOOKUP: begin
              if (rdata.dest == addr_q) begin
                found_q <= 1'b1; hit_e_q <= rdata;
              end
            end
            MODE_BEST: begin
              if ((rdata.role & role_q) == role_q &&
                  (!best_q || rdata.hops < hit_e_q.hops)) begin
                best_q <= 1'b1; found_q <= 1'b1; hit_e_q <= rdata;
              end
            end
            MODE_SWEEP: begin
              if (rdata.age <= life_q) wr_q <= wr_q + AW'(1);
              if (at_end)
                cnt_q <= (rdata.age <= life_q) ? CW'(wr_q) + CW'(1) : CW'(wr_q);
            end
            MODE_DUMP: begin
              result_valid_o  <= 1'b1;
              status_o        <= ST_OK;
              entry_address_o <= rdata.dest;
              next_hop_o      <= rdata.via;
              hops_o          <= rdata.hops;
              entry_role_o    <= rdata.role;
              entry_load_o    <= rdata.load;
              entry_snr_o     <= rdata.snr;
              entry_count_o   <= 6'(cnt_q);
              last_o          <= at_end;
            end
            default: ;
          endcase
          if (at_end || scan_hit) begin
            if (mode_e'(mode_q) == MODE_ADV) state_q <= S_DECIDE;
            else if (mode_e'(mode_q) == MODE_DUMP) state_q <= S_IDLE;
            else state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + AW'(1);
            state_q <= S_RD;
          end
        end
        S_DECIDE: begin
          idx_q <= '0;
          if (found_q) begin
            hit_e_q <= adv_e;
            wr_q <= hit_q;
            state_q <= S_WR;
          end else if (cnt_q >= CW'(TableEntries)) begin
            st_q <= ST_FULL;
            state_q <= (sender_q && cnt_q != '0) ? S_SRD : S_DONE;
          end else if ({1'b0, metric_q} > {1'b0, maxh_q} + 9'd1) begin
            st_q <= ST_METRIC;
            state_q <= (sender_q && cnt_q != '0) ? S_SRD : S_DONE;
          end else begin
            hit_e_q <= '{dest: dst_q, via: via_q, hops: metric_q, role: role_q,
                         load: load_q, snr: 8'd0, age: 16'd0};
            wr_q  <= AW'(cnt_q);
            hit_q <= AW'(cnt_q);
            cnt_q <= cnt_q + CW'(1);
            found_q <= 1'b1;
            state_q <= S_WR;
          end
        end
        S_WR: begin
          state_q <= sender_q ? S_SRD : S_DONE;
        end
        S_SRD: state_q <= S_SCHK;
        S_SCHK: begin
          if (rdata.dest == via_q) begin
            hit_q <= idx_q;
            hit_e_q <= rdata;
            state_q <= S_SWR;
          end else if (at_end) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + AW'(1);
            state_q <= S_SRD;
          end
        end
        S_SWR: state_q <= S_DONE;
        S_DONE: begin
          result_valid_o <= 1'b1;
          last_o <= 1'b1;
          entry_count_o <= 6'(cnt_q);
          status_o <= st_q;
          entry_address_o <= '0; next_hop_o <= '0; hops_o <= '0;
          entry_role_o <= '0; entry_load_o <= '0; entry_snr_o <= '0;
          unique case (mode_e'(mode_q))
            MODE_ADV: begin
              entry_address_o <= dst_q;
              if (st_q == ST_OK) begin
                entry_address_o <= res_q.dest;
                next_hop_o <= res_q.via; hops_o <= res_q.hops;
                entry_role_o <= res_q.role; entry_load_o <= res_q.load;
                entry_snr_o <= res_q.snr;
              end
            end
            MODE_REFRESH, MODE_LOOKUP, MODE_BEST: begin
              status_o <= found_q ? ST_OK : ST_NOTFOUND;
              entry_address_o <= (mode_e'(mode_q) == MODE_BEST) ? 16'd0 : addr_q;
              if (found_q) begin
                entry_address_o <= hit_e_q.dest;
                next_hop_o <= hit_e_q.via; hops_o <= hit_e_q.hops;
                entry_role_o <= hit_e_q.role; entry_load_o <= hit_e_q.load;
                entry_snr_o <= hit_e_q.snr;
              end
            end
            MODE_DUMP: status_o <= ST_NOTFOUND;
            default: ;
          endcase
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Advertise result: the written entry, with the SNR update when it hits it.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WR) res_q <= hit_e_q;
    else if (state_q == S_SWR && hit_q == wr_q && st_q == ST_OK) res_q.snr <= snr_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without strobe");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TableEntries)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("command not taken");
endmodule
